[hdl/plli_pkg.sv]
// Shared constants, codes and pipeline payload types for the PWL interpolator.
package plli_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int QW          = 33;            // quotient bits, q <= |dv| < 2^33
  localparam int PW          = 32 + QW;       // product bits

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_EVAL = 1'b1
  } action_t;

  // register index taken from paddr[2]
  typedef enum logic {
    REG_ENTRIES = 1'b0,
    REG_SPARE   = 1'b1
  } reg_idx_t;

  // segment walk payload
  typedef struct packed {
    logic signed [31:0] x;
    logic [CNT_W-1:0]   n;
    logic               found;
    logic signed [31:0] k0;
    logic signed [31:0] k1;
    logic signed [31:0] v0;
    logic signed [31:0] v1;
    logic signed [31:0] kfirst;
    logic signed [31:0] vfirst;
    logic signed [31:0] klast;
    logic signed [31:0] vlast;
  } srch_t;

  // divide operands
  typedef struct packed {
    logic               bypass;
    logic signed [31:0] byp_val;
    logic [31:0]        off;
    logic [QW-1:0]      mag;
    logic               neg;
    logic [31:0]        span;
    logic signed [31:0] v0;
  } op_t;

  // divider stage payload
  typedef struct packed {
    logic               bypass;
    logic signed [31:0] byp_val;
    logic               neg;
    logic [31:0]        span;
    logic signed [31:0] v0;
    logic [PW-1:0]      prod;
    logic [31:0]        rem;
    logic [QW-1:0]      q;
  } div_t;

endpackage

[hdl/plli_search.sv]
// Breakpoint table, pipelined segment walk and operand setup stage.
module plli_search import plli_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              ld_en,
  input  logic [IDX_W-1:0]  ld_idx,
  input  logic [31:0]       ld_key,
  input  logic [31:0]       ld_val,
  input  logic              ev_en,
  input  logic [31:0]       ev_x,
  input  logic [4:0]        n_in,
  output logic              op_vld,
  output op_t               op,
  output logic              busy
);

  logic [31:0]      key_r [TABLE_DEPTH];
  logic [31:0]      val_r [TABLE_DEPTH];
  srch_t            srch_r   [TABLE_DEPTH];
  srch_t            srch_in  [TABLE_DEPTH];
  srch_t            srch_nxt [TABLE_DEPTH];
  logic             vld_r [TABLE_DEPTH];
  logic [CNT_W-1:0] n_clamp;
  logic [TABLE_DEPTH-1:0] vld_vec;
  op_t              op_r, op_nxt;
  logic             op_vld_r;
  srch_t            last;
  logic [32:0]      dv;

  genvar e;
  generate
    for (e = 0; e < TABLE_DEPTH; e++) begin : g_tab
      always_ff @(posedge clk) begin
        if (ld_en && (32'(ld_idx) == e)) begin
          key_r[e] <= ld_key;
          val_r[e] <= ld_val;
        end
      end
    end
  endgenerate

  always_comb begin
    if (32'(n_in) > TABLE_DEPTH) n_clamp = CNT_W'(TABLE_DEPTH);
    else                         n_clamp = CNT_W'(n_in);
  end

  generate
    for (e = 0; e < TABLE_DEPTH; e++) begin : g_walk
      if (e == 0) begin : g_first
        always_comb begin
          srch_in[e]        = '0;
          srch_in[e].x      = ev_x;
          srch_in[e].n      = n_clamp;
          srch_in[e].kfirst = key_r[0];
          srch_in[e].vfirst = val_r[0];
          srch_in[e].klast  = key_r[0];
          srch_in[e].vlast  = val_r[0];
        end
      end else begin : g_next
        assign srch_in[e] = srch_r[e-1];
      end

      always_comb begin
        srch_nxt[e] = srch_in[e];
        if (CNT_W'(e + 1) == srch_in[e].n) begin
          srch_nxt[e].klast = key_r[e];
          srch_nxt[e].vlast = val_r[e];
        end
        if (e + 1 < TABLE_DEPTH) begin
          // first segment holding x wins
          if (!srch_in[e].found && (32'(srch_in[e].n) >= e + 2) &&
              (srch_in[e].x >= $signed(key_r[e])) &&
              (srch_in[e].x <= $signed(key_r[(e + 1) % TABLE_DEPTH]))) begin
            srch_nxt[e].found = 1'b1;
            srch_nxt[e].k0    = key_r[e];
            srch_nxt[e].k1    = key_r[(e + 1) % TABLE_DEPTH];
            srch_nxt[e].v0    = val_r[e];
            srch_nxt[e].v1    = val_r[(e + 1) % TABLE_DEPTH];
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[e] <= 1'b0;
        end else if (adv) begin
          vld_r[e] <= (e == 0) ? ev_en : vld_r[(e + TABLE_DEPTH - 1) % TABLE_DEPTH];
        end
      end

      always_ff @(posedge clk) begin
        if (adv) srch_r[e] <= srch_nxt[e];
      end

      assign vld_vec[e] = vld_r[e];
    end
  endgenerate

  assign last = srch_r[TABLE_DEPTH-1];

  always_comb begin
    dv             = {last.v1[31], last.v1} - {last.v0[31], last.v0};
    op_nxt         = '0;
    op_nxt.off     = last.x - last.k0;
    op_nxt.span    = last.k1 - last.k0;
    op_nxt.neg     = dv[32];
    op_nxt.mag     = dv[32] ? (~dv + 33'd1) : dv;
    op_nxt.v0      = last.v0;
    op_nxt.bypass  = 1'b1;
    if (last.n == '0)                op_nxt.byp_val = '0;
    else if (last.n == CNT_W'(1))    op_nxt.byp_val = last.vfirst;
    else if (last.x <= last.kfirst)  op_nxt.byp_val = last.vfirst;
    else if (last.x >= last.klast)   op_nxt.byp_val = last.vlast;
    else if (!last.found)            op_nxt.byp_val = last.vlast;
    else if (op_nxt.span == '0)      op_nxt.byp_val = last.v0;
    else begin
      op_nxt.byp_val = '0;
      op_nxt.bypass  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_vld_r <= 1'b0;
    end else if (adv) begin
      op_vld_r <= vld_r[TABLE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) op_r <= op_nxt;
  end

  assign op     = op_r;
  assign op_vld = op_vld_r;
  assign busy   = |vld_vec;

endmodule

[hdl/plli_div.sv]
// Multiply, one-bit-per-stage restoring divide, and signed add with saturation.
module plli_div import plli_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        op_vld,
  input  op_t         op,
  output logic        res_vld,
  output logic [31:0] res
);

  div_t        mul_r, mul_nxt;
  logic        mul_vld_r;
  div_t        dv_r   [QW];
  div_t        dv_in  [QW];
  div_t        dv_nxt [QW];
  logic        dvld_r [QW];
  logic [31:0] res_r;
  logic        res_vld_r;
  logic [34:0] sum;
  logic [34:0] qx;
  div_t        fin;

  always_comb begin
    mul_nxt         = '0;
    mul_nxt.bypass  = op.bypass;
    mul_nxt.byp_val = op.byp_val;
    mul_nxt.neg     = op.neg;
    mul_nxt.span    = op.span;
    mul_nxt.v0      = op.v0;
    mul_nxt.prod    = {{QW{1'b0}}, op.off} * {32'b0, op.mag};
  end

  always_ff @(posedge clk) begin
    if (!rst_n)   mul_vld_r <= 1'b0;
    else if (adv) mul_vld_r <= op_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) mul_r <= mul_nxt;
  end

  genvar s;
  generate
    for (s = 0; s < QW; s++) begin : g_div
      logic [32:0] t;
      logic        ge;
      if (s == 0) begin : g_first
        always_comb begin
          dv_in[s]     = mul_r;
          // quotient fits QW bits, so the top remainder is below span
          dv_in[s].rem = mul_r.prod[PW-1:QW];
          dv_in[s].q   = '0;
        end
      end else begin : g_next
        assign dv_in[s] = dv_r[s-1];
      end

      always_comb begin
        t           = {dv_in[s].rem, dv_in[s].prod[QW-1-s]};
        ge          = (t >= {1'b0, dv_in[s].span});
        dv_nxt[s]   = dv_in[s];
        dv_nxt[s].rem = ge ? 32'(t - {1'b0, dv_in[s].span}) : t[31:0];
        dv_nxt[s].q[QW-1-s] = ge;
      end

      always_ff @(posedge clk) begin
        if (!rst_n)   dvld_r[s] <= 1'b0;
        else if (adv) dvld_r[s] <= (s == 0) ? mul_vld_r : dvld_r[(s + QW - 1) % QW];
      end

      always_ff @(posedge clk) begin
        if (adv) dv_r[s] <= dv_nxt[s];
      end
    end
  endgenerate

  assign fin = dv_r[QW-1];

  always_comb begin
    qx  = {2'b0, fin.q};
    sum = {{3{fin.v0[31]}}, fin.v0} + (fin.neg ? (~qx + 35'd1) : qx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n)   res_vld_r <= 1'b0;
    else if (adv) res_vld_r <= dvld_r[QW-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fin.bypass)                         res_r <= fin.byp_val;
      else if (!sum[34] && (sum[33:31] != 3'b000)) res_r <= 32'h7FFF_FFFF;
      else if (sum[34] && (sum[33:31] != 3'b111))  res_r <= 32'h8000_0000;
      else                                    res_r <= sum[31:0];
    end
  end

  assign res     = res_r;
  assign res_vld = res_vld_r;

endmodule

[hdl/piecewise_linear_lut_interpolator.sv]
// Top level: stream ports, APB register, output stage and checks.
//
//  channel | dir | handshake                  | contents
//  in_     | in  | in_tvalid / in_tready      | tuser action, tdata load or x
//  out_    | out | out_tvalid / out_tready    | tdata y
//  cfg_    | in  | APB psel/penable, pready=1 | entries_in_use at 0x0
//
// One item accepted per cycle unless the output stalls or a load waits; an
// evaluate item's y passes the 16-stage segment walk, setup, multiply, 33-stage
// divider, final add, output. A load waits until the walk holds no evaluate item.
// Synchronous active-low reset clears valid bits and entries_in_use only;
// table contents are undefined until loaded.
// A stall at the output freezes the whole pipeline; nothing is dropped.
module piecewise_linear_lut_interpolator import plli_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         in_tuser,    // [0] action
  // [3:0] entry_index, [35:4] entry_key, [67:36] entry_value, [99:68] sample_in
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,   // [31:0] sample_out
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [4:0]  entries_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        adv;
  logic        busy;
  logic        in_acc;
  logic        op_vld;
  op_t         op;
  logic        res_vld;
  logic [31:0] res;
  reg_idx_t    cfg_idx;

  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_idx == REG_ENTRIES) ? {27'b0, entries_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_idx == REG_ENTRIES)) begin
      entries_r <= cfg_pwdata[4:0];
    end
  end

  assign adv       = !out_valid_r || out_tready;
  // a load must not change the table under an evaluate still in the walk
  assign in_tready = adv && !((action_t'(in_tuser) == ACT_LOAD) && busy);
  assign in_acc    = in_tvalid && in_tready;

  plli_search u_search (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .ld_en  (in_acc && (action_t'(in_tuser) == ACT_LOAD)),
    .ld_idx (in_tdata[3:0]),
    .ld_key (in_tdata[35:4]),
    .ld_val (in_tdata[67:36]),
    .ev_en  (in_acc && (action_t'(in_tuser) == ACT_EVAL)),
    .ev_x   (in_tdata[99:68]),
    .n_in   (entries_r),
    .op_vld (op_vld),
    .op     (op),
    .busy   (busy)
  );

  plli_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .op_vld  (op_vld),
    .op      (op),
    .res_vld (res_vld),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n)   out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= res_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) out_data_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_load_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (action_t'(in_tuser) == ACT_LOAD)) |-> !busy)
    else $error("load accepted while walk busy");

  a_eval_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (action_t'(in_tuser) == ACT_EVAL)) |=> busy)
    else $error("evaluate item lost at walk entry");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && res_vld) |=> (res_vld && $stable(res)))
    else $error("divider output changed during stall");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !busy) |-> in_tready)
    else $error("input stalled with free pipeline");

endmodule
